/* design/itwt_pkg.sv */
// Package with the token codes, microcode types and the sequencer program.
`default_nettype none
package itwt_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int NUM_DIGITS     = 10;
	localparam int PC_W           = 4;

	localparam logic [4:0] TOK_ZERO      = 5'd0;
	localparam logic [4:0] TOK_TEEN_BASE = 5'd10;
	localparam logic [4:0] TOK_TENS_BASE = 5'd18;
	localparam logic [4:0] TOK_HUNDRED   = 5'd28;
	localparam logic [4:0] TOK_THOUSAND  = 5'd29;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_CONV,
		OP_EMIT,
		OP_BRANCH,
		OP_NEXT
	} op_t;

	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_ALLZERO,
		COND_GRP_NZ,
		COND_H_NZ,
		COND_TEEN,
		COND_TENS,
		COND_UNIT_NZ,
		COND_SCALE,
		COND_LAST_GRP
	} cond_t;

	typedef enum logic [2:0] {
		SRC_ZERO,
		SRC_HUND_DIGIT,
		SRC_HUNDRED,
		SRC_TEEN,
		SRC_TENS,
		SRC_UNIT,
		SRC_SCALE
	} src_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		src_t            src;
		logic [PC_W-1:0] nxt;  // step taken when the condition holds
		logic [PC_W-1:0] alt;  // step taken when it does not
	} ctrl_word_t;

	// Program steps.
	localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] PC_CONV   = 4'd1;
	localparam logic [PC_W-1:0] PC_ZCHK   = 4'd2;
	localparam logic [PC_W-1:0] PC_GRP    = 4'd3;
	localparam logic [PC_W-1:0] PC_HDIG   = 4'd4;
	localparam logic [PC_W-1:0] PC_HUND   = 4'd5;
	localparam logic [PC_W-1:0] PC_TEEN   = 4'd6;
	localparam logic [PC_W-1:0] PC_TENS   = 4'd7;
	localparam logic [PC_W-1:0] PC_UNIT   = 4'd8;
	localparam logic [PC_W-1:0] PC_SCALE  = 4'd9;
	localparam logic [PC_W-1:0] PC_NEXT   = 4'd10;

	function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			PC_WAIT:  w = '{OP_WAIT,   COND_ALWAYS,   SRC_ZERO,       PC_CONV,  PC_WAIT};
			PC_CONV:  w = '{OP_CONV,   COND_ALWAYS,   SRC_ZERO,       PC_ZCHK,  PC_CONV};
			PC_ZCHK:  w = '{OP_EMIT,   COND_ALLZERO,  SRC_ZERO,       PC_WAIT,  PC_GRP};
			PC_GRP:   w = '{OP_BRANCH, COND_GRP_NZ,   SRC_ZERO,       PC_HDIG,  PC_NEXT};
			PC_HDIG:  w = '{OP_EMIT,   COND_H_NZ,     SRC_HUND_DIGIT, PC_HUND,  PC_HUND};
			PC_HUND:  w = '{OP_EMIT,   COND_H_NZ,     SRC_HUNDRED,    PC_TEEN,  PC_TEEN};
			PC_TEEN:  w = '{OP_EMIT,   COND_TEEN,     SRC_TEEN,       PC_SCALE, PC_TENS};
			PC_TENS:  w = '{OP_EMIT,   COND_TENS,     SRC_TENS,       PC_UNIT,  PC_UNIT};
			PC_UNIT:  w = '{OP_EMIT,   COND_UNIT_NZ,  SRC_UNIT,       PC_SCALE, PC_SCALE};
			PC_SCALE: w = '{OP_EMIT,   COND_SCALE,    SRC_SCALE,      PC_NEXT,  PC_NEXT};
			PC_NEXT:  w = '{OP_NEXT,   COND_LAST_GRP, SRC_ZERO,       PC_WAIT,  PC_GRP};
			default:  w = '{OP_WAIT,   COND_ALWAYS,   SRC_ZERO,       PC_WAIT,  PC_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* design/integer_to_word_tokens_core.sv */
// Top level: spells a non-negative integer as a run of English word tokens.
`default_nettype none
// Each accepted value is first converted to ten decimal digits by a bit-serial
// shift-and-add-three loop, one input bit per cycle. A small microcoded
// sequencer then walks the four three-digit groups from the billions down, one
// program step per cycle while the output register can take a word, and sends
// one word token per beat with tlast on the final word. The next value is
// accepted once the sequencer is back at its wait step; the last word may still
// be waiting in the output register then.
module integer_to_word_tokens_core
	import itwt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [30:0] value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [4:0] word
	output logic             m_axis_tlast
);

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	logic [PC_W-1:0]                 pc_q;
	logic [1:0]                      grp_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [NUM_DIGITS-1:0][3:0]      bcd_q;
	logic                            out_valid_q;
	logic [4:0]                      out_word_q;
	logic                            out_last_q;

	ctrl_word_t                      cw;
	logic [NUM_DIGITS-1:0][3:0]      bcd_adj;
	logic [NUM_DIGITS*4-1:0]         bcd_shift;
	logic [3:0]                      dig_h, dig_t, dig_u;
	logic                            lower_nz;
	logic                            cond_ok;
	logic                            more_in_grp;
	logic [4:0]                      tok;
	logic                            can_load;
	logic                            emit_fire;

	assign cw = prog_rom(pc_q);

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end
	// The top bit shifted out is always zero since the value stays below 2^31.
	assign bcd_shift = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0],
		val_q[VALUE_BITS-1]};

	// Digits of the current group and whether any lower group is nonzero.
	always_comb begin
		case (grp_q)
			2'd0: begin
				dig_h    = bcd_q[2];
				dig_t    = bcd_q[1];
				dig_u    = bcd_q[0];
				lower_nz = 1'b0;
			end
			2'd1: begin
				dig_h    = bcd_q[5];
				dig_t    = bcd_q[4];
				dig_u    = bcd_q[3];
				lower_nz = |bcd_q[2:0];
			end
			2'd2: begin
				dig_h    = bcd_q[8];
				dig_t    = bcd_q[7];
				dig_u    = bcd_q[6];
				lower_nz = |bcd_q[5:0];
			end
			default: begin
				dig_h    = 4'd0;
				dig_t    = 4'd0;
				dig_u    = bcd_q[9];
				lower_nz = |bcd_q[8:0];
			end
		endcase
	end

	always_comb begin
		case (cw.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_ALLZERO:  cond_ok = ~|bcd_q;
			COND_GRP_NZ:   cond_ok = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_u != 4'd0);
			COND_H_NZ:     cond_ok = dig_h != 4'd0;
			COND_TEEN:     cond_ok = dig_t == 4'd1;
			COND_TENS:     cond_ok = dig_t >= 4'd2;
			COND_UNIT_NZ:  cond_ok = dig_u != 4'd0;
			COND_SCALE:    cond_ok = grp_q != 2'd0;
			COND_LAST_GRP: cond_ok = grp_q == 2'd0;
			default:       cond_ok = 1'b0;
		endcase
	end

	// Token and whether another word of this group still follows it.
	always_comb begin
		case (cw.src)
			SRC_ZERO: begin
				tok         = TOK_ZERO;
				more_in_grp = 1'b0;
			end
			SRC_HUND_DIGIT: begin
				tok         = {1'b0, dig_h};
				more_in_grp = 1'b1;
			end
			SRC_HUNDRED: begin
				tok         = TOK_HUNDRED;
				more_in_grp = (dig_t != 4'd0) || (dig_u != 4'd0) || (grp_q != 2'd0);
			end
			SRC_TEEN: begin
				tok         = TOK_TEEN_BASE + {1'b0, dig_u};
				more_in_grp = grp_q != 2'd0;
			end
			SRC_TENS: begin
				tok         = TOK_TENS_BASE + {1'b0, dig_t};
				more_in_grp = (dig_u != 4'd0) || (grp_q != 2'd0);
			end
			SRC_UNIT: begin
				tok         = {1'b0, dig_u};
				more_in_grp = grp_q != 2'd0;
			end
			SRC_SCALE: begin
				tok         = TOK_THOUSAND + {3'd0, grp_q} - 5'd1;
				more_in_grp = 1'b0;
			end
			default: begin
				tok         = TOK_ZERO;
				more_in_grp = 1'b0;
			end
		endcase
	end

	assign can_load      = !out_valid_q || m_axis_tready;
	assign emit_fire     = (cw.op == OP_EMIT) && cond_ok && can_load;
	assign s_axis_tready = cw.op == OP_WAIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			grp_q       <= 2'd3;
			cnt_q       <= '0;
			val_q       <= '0;
			bcd_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= emit_fire || (out_valid_q && !m_axis_tready);
			case (cw.op)
				OP_WAIT: begin
					if (s_axis_tvalid) begin
						val_q <= s_axis_tdata[VALUE_BITS-1:0];
						bcd_q <= '0;
						cnt_q <= '0;
						grp_q <= 2'd3;
						pc_q  <= cw.nxt;
					end
				end
				OP_CONV: begin
					bcd_q <= bcd_shift;
					val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						pc_q <= cw.nxt;
					end
				end
				OP_EMIT: begin
					if (!cond_ok) begin
						pc_q <= cw.alt;
					end else if (can_load) begin
						out_word_q  <= tok;
						out_last_q  <= !more_in_grp && !lower_nz;
						pc_q        <= cw.nxt;
					end
				end
				OP_BRANCH: begin
					pc_q <= cond_ok ? cw.nxt : cw.alt;
				end
				OP_NEXT: begin
					if (cond_ok) begin
						pc_q <= cw.nxt;
					end else begin
						grp_q <= grp_q - 2'd1;
						pc_q  <= cw.alt;
					end
				end
				default: begin
					pc_q <= PC_WAIT;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_word_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

/* tb/word_token_checker.sv */
// Checker that spells each accepted value and compares the word stream beat by beat.
`timescale 1ns / 100ps
module word_token_checker
	import itwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_data,
	input  logic        out_last,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [4:0] word;
		logic       last;
	} word_beat_t;

	word_beat_t spelled_words[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Appends the spelling of one value to the queue of words still to come.
	function automatic void spell_value(input logic [30:0] val);
		int unsigned rest;
		int unsigned grp;
		int unsigned hund;
		int unsigned tens;
		int unsigned unit;
		int unsigned groups[4];
		logic [4:0] words[$];
		word_beat_t beat;
		rest = val;
		for (int i = 0; i < 4; i++) begin
			groups[i] = rest % 1000;
			rest = rest / 1000;
		end
		if (val == '0) begin
			words.push_back(TOK_ZERO);
		end else begin
			for (int scale = 3; scale >= 0; scale--) begin
				grp = groups[scale];
				if (grp != 0) begin
					hund = grp / 100;
					tens = (grp % 100) / 10;
					unit = grp % 10;
					if (hund != 0) begin
						words.push_back(5'(hund));
						words.push_back(TOK_HUNDRED);
					end
					if (tens == 1) begin
						words.push_back(TOK_TEEN_BASE + 5'(unit));
					end else begin
						if (tens >= 2)
							words.push_back(TOK_TENS_BASE + 5'(tens));
						if (unit != 0)
							words.push_back(5'(unit));
					end
					if (scale != 0)
						words.push_back(TOK_THOUSAND + 5'(scale - 1));
				end
			end
		end
		foreach (words[i]) begin
			beat.word = words[i];
			beat.last = (i == words.size() - 1);
			spelled_words.push_back(beat);
		end
	endfunction

	function automatic void flag_mismatch(input word_beat_t want, input word_beat_t got,
		input bit none_waiting);
		mismatches++;
		if (mismatches <= 10) begin
			if (none_waiting)
				$display("%0t: unexpected word %0d last %0d with nothing outstanding",
					$realtime, got.word, got.last);
			else
				$display("%0t: expected word %0d last %0d, got word %0d last %0d",
					$realtime, want.word, want.last, got.word, got.last);
		end
	endfunction

	always @(posedge clk) begin
		word_beat_t got;
		word_beat_t want;
		if (arst_n) begin
			// Output beats are retired first; they can never belong to a value
			// accepted at the same edge.
			if (out_valid && out_ready) begin
				got.word = out_data[4:0];
				got.last = out_last;
				if (spelled_words.size() == 0) begin
					want = '0;
					flag_mismatch(want, got, 1'b1);
				end else begin
					want = spelled_words.pop_front();
					if (got.word != want.word || got.last != want.last)
						flag_mismatch(want, got, 1'b0);
				end
			end
			if (in_valid && in_ready)
				spell_value(in_data[30:0]);
			pending = spelled_words.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, value stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;

	localparam int MAX_VALUE = 2147483647;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [30:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [4:0] word
	logic        m_axis_tlast;

	int mismatches;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_go = 1'b0;

	integer_to_word_tokens_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	word_token_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Output side: random back-pressure, plus one long hold-off once requested.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offers one value and returns at the edge where it is taken. Ready is
	// looked at on the falling edge, where it is settled.
	task automatic send_value(input logic [30:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, val};
		forever begin
			@(negedge clk);
			if (s_axis_tready)
				break;
		end
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	function automatic int unsigned rand_group();
		case ($urandom_range(3))
			0: return 0;
			1: return $urandom_range(10, 19) + 100 * $urandom_range(9);
			2: return 100 * $urandom_range(1, 9);
			default: return $urandom_range(999);
		endcase
	endfunction

	function automatic logic [30:0] pick_value();
		longint unsigned v;
		case ($urandom_range(4))
			0: v = $urandom & 32'h7FFF_FFFF;
			1: v = $urandom_range(999);
			2: v = $urandom_range(999999);
			default: begin
				// Built from three-digit groups so that zero groups, teens and
				// round hundreds turn up often in the three lower positions.
				v = longint'($urandom_range(2)) * 1000000000 + rand_group() * 1000000
					+ rand_group() * 1000 + rand_group();
				if (v > MAX_VALUE)
					v = v - 1000000000;
			end
		endcase
		return v[30:0];
	endfunction

	task automatic run_phase(input int count, input bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20)
				hold_go <= 1'b1;
			send_value(pick_value());
		end
		wait_drained();
	endtask

	initial begin
		int corner_values[$];
		corner_values = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 115, 999,
			1000, 1001, 1000000, 1000001, 1000000000, 1000000115, 2000000000,
			123456789, 1777777777, MAX_VALUE};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i])
			send_value(31'(corner_values[i]));
		wait_drained();

		tx_idle_pct = 20;
		rx_idle_pct = 64;
		run_phase(100, 1'b0);
		tx_idle_pct = 64;
		rx_idle_pct = 20;
		run_phase(100, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(100, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
design/itwt_pkg.sv
design/integer_to_word_tokens_core.sv
tb/word_token_checker.sv
tb/tb_top.sv
